[rtl/ycc2rgb_pkg.sv]
package ycc2rgb_pkg;

   localparam int NPIX      = 4;
   localparam int PIX_W     = 8;
   localparam int COEF_W    = 16;
   localparam int SAMP_W    = 9;
   localparam int PROD_W    = 26;
   localparam int SUM_W     = 30;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LUMA     = 3'd0,
      CSR_CR_RED   = 3'd1,
      CSR_CR_GREEN = 3'd2,
      CSR_CB_GREEN = 3'd3,
      CSR_CB_BLUE  = 3'd4
   } csr_idx_type;

   localparam logic [COEF_W-1:0] LUMA_RST     = 16'd9535;
   localparam logic [COEF_W-1:0] CR_RED_RST   = 16'd13074;
   localparam logic [COEF_W-1:0] CR_GREEN_RST = 16'd6660;
   localparam logic [COEF_W-1:0] CB_GREEN_RST = 16'd3203;
   localparam logic [COEF_W-1:0] CB_BLUE_RST  = 16'd16531;

   localparam logic [SAMP_W-1:0] LUMA_OFS   = 9'd16;
   localparam logic [SAMP_W-1:0] CHROMA_OFS = 9'd128;
   localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;
   localparam logic [PIX_W-1:0]  PIX_MIN    = 8'd0;

   typedef struct packed {
      logic [PIX_W-1:0] luma_p0;
      logic [PIX_W-1:0] luma_p1;
      logic [PIX_W-1:0] luma_p2;
      logic [PIX_W-1:0] luma_p3;
      logic [PIX_W-1:0] chroma_b_p0;
      logic [PIX_W-1:0] chroma_b_p1;
      logic [PIX_W-1:0] chroma_b_p2;
      logic [PIX_W-1:0] chroma_b_p3;
      logic [PIX_W-1:0] chroma_r_p0;
      logic [PIX_W-1:0] chroma_r_p1;
      logic [PIX_W-1:0] chroma_r_p2;
      logic [PIX_W-1:0] chroma_r_p3;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_p0;
      logic [PIX_W-1:0] red_p1;
      logic [PIX_W-1:0] red_p2;
      logic [PIX_W-1:0] red_p3;
      logic [PIX_W-1:0] green_p0;
      logic [PIX_W-1:0] green_p1;
      logic [PIX_W-1:0] green_p2;
      logic [PIX_W-1:0] green_p3;
      logic [PIX_W-1:0] blue_p0;
      logic [PIX_W-1:0] blue_p1;
      logic [PIX_W-1:0] blue_p2;
      logic [PIX_W-1:0] blue_p3;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] luma;
      logic [COEF_W-1:0] cr_red;
      logic [COEF_W-1:0] cr_green;
      logic [COEF_W-1:0] cb_green;
      logic [COEF_W-1:0] cb_blue;
   } coef_type;

   // partial products of one pixel
   typedef struct packed {
      logic signed [PROD_W-1:0] ly;
      logic signed [PROD_W-1:0] pr;
      logic signed [PROD_W-1:0] pgr;
      logic signed [PROD_W-1:0] pgb;
      logic signed [PROD_W-1:0] pb;
   } prod_type;

   typedef prod_type [NPIX-1:0] prod_quad_type;

   // rounded sums of one pixel
   typedef struct packed {
      logic signed [SUM_W-1:0] r;
      logic signed [SUM_W-1:0] g;
      logic signed [SUM_W-1:0] b;
   } sum_type;

   typedef sum_type [NPIX-1:0] sum_quad_type;

   function automatic logic signed [PROD_W-1:0] ext_coef(input logic [COEF_W-1:0] c);
      ext_coef = {{(PROD_W-COEF_W){1'b0}}, c};
   endfunction

   function automatic logic signed [PROD_W-1:0] ext_samp(input logic signed [SAMP_W-1:0] s);
      ext_samp = {{(PROD_W-SAMP_W){s[SAMP_W-1]}}, s};
   endfunction

   function automatic logic signed [SUM_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
      ext_prod = {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

endpackage

[rtl/ycbcr_to_rgb_quad.sv]
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_data  (Y, Cb, Cr of a 2x2 quad)
// rsp      out        rsp_valid/rsp_stall   rsp_data  (R, G, B of the quad)
// csr      in         csr_valid/csr_ready   csr_index, csr_wdata (gain registers)
//
// one quad per clock while req_stall is low; stages: multiply, sum and round,
// shift and clamp, each closed by a register stage.
// reset clears the stage valid bits and loads the default gains.
// a stalled stage holds its item and fills the bubbles in front of it, so
// req_stall only rises once all three stages hold items and rsp_stall is high.
module ycbcr_to_rgb_quad #(
   parameter int COEF_FRAC_BITS = 13
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ycc2rgb_pkg::req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ycc2rgb_pkg::rsp_type                  rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ycc2rgb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ycc2rgb_pkg::COEF_W-1:0]        csr_wdata
);

   ycc2rgb_pkg::coef_type      coef_ff;
   ycc2rgb_pkg::coef_type      coef_in;

   logic                       mult_valid;
   logic                       mult_stall;
   ycc2rgb_pkg::prod_quad_type mult_data;
   logic                       sum_valid;
   logic                       sum_stall;
   ycc2rgb_pkg::sum_quad_type  sum_data;

   assign csr_ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ycc2rgb_pkg::CSR_LUMA:     coef_in.luma     = csr_wdata;
            ycc2rgb_pkg::CSR_CR_RED:   coef_in.cr_red   = csr_wdata;
            ycc2rgb_pkg::CSR_CR_GREEN: coef_in.cr_green = csr_wdata;
            ycc2rgb_pkg::CSR_CB_GREEN: coef_in.cb_green = csr_wdata;
            ycc2rgb_pkg::CSR_CB_BLUE:  coef_in.cb_blue  = csr_wdata;
            default:                   coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.luma     <= ycc2rgb_pkg::LUMA_RST;
         coef_ff.cr_red   <= ycc2rgb_pkg::CR_RED_RST;
         coef_ff.cr_green <= ycc2rgb_pkg::CR_GREEN_RST;
         coef_ff.cb_green <= ycc2rgb_pkg::CB_GREEN_RST;
         coef_ff.cb_blue  <= ycc2rgb_pkg::CB_BLUE_RST;
      end else begin
         coef_ff <= coef_in;
      end
   end

   ycc2rgb_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .coef      (coef_ff),
      .out_valid (mult_valid),
      .out_stall (mult_stall),
      .out_data  (mult_data)
   );

   ycc2rgb_sum #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mult_valid),
      .in_stall  (mult_stall),
      .in_data   (mult_data),
      .out_valid (sum_valid),
      .out_stall (sum_stall),
      .out_data  (sum_data)
   );

   ycc2rgb_clamp #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_stall  (sum_stall),
      .in_data   (sum_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

[rtl/ycc2rgb_mult.sv]
module ycc2rgb_mult (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  ycc2rgb_pkg::req_type        in_data,
   input  ycc2rgb_pkg::coef_type       coef,
   output logic                        out_valid,
   input  logic                        out_stall,
   output ycc2rgb_pkg::prod_quad_type  out_data
);

   logic [ycc2rgb_pkg::PIX_W-1:0] luma  [ycc2rgb_pkg::NPIX];
   logic [ycc2rgb_pkg::PIX_W-1:0] cb_in [ycc2rgb_pkg::NPIX];
   logic [ycc2rgb_pkg::PIX_W-1:0] cr_in [ycc2rgb_pkg::NPIX];

   logic                       adv;
   logic                       valid_ff;
   logic                       valid_in;
   ycc2rgb_pkg::prod_quad_type prod_ff;
   ycc2rgb_pkg::prod_quad_type prod_in;

   assign luma[0]  = in_data.luma_p0;
   assign luma[1]  = in_data.luma_p1;
   assign luma[2]  = in_data.luma_p2;
   assign luma[3]  = in_data.luma_p3;
   assign cb_in[0] = in_data.chroma_b_p0;
   assign cb_in[1] = in_data.chroma_b_p1;
   assign cb_in[2] = in_data.chroma_b_p2;
   assign cb_in[3] = in_data.chroma_b_p3;
   assign cr_in[0] = in_data.chroma_r_p0;
   assign cr_in[1] = in_data.chroma_r_p1;
   assign cr_in[2] = in_data.chroma_r_p2;
   assign cr_in[3] = in_data.chroma_r_p3;

   for (genvar p = 0; p < ycc2rgb_pkg::NPIX; p++) begin : g_lane
      logic signed [ycc2rgb_pkg::SAMP_W-1:0] y_s;
      logic signed [ycc2rgb_pkg::SAMP_W-1:0] cb_s;
      logic signed [ycc2rgb_pkg::SAMP_W-1:0] cr_s;

      // offsets stay within 9 bits signed
      assign y_s  = signed'({1'b0, luma[p]}  - ycc2rgb_pkg::LUMA_OFS);
      assign cb_s = signed'({1'b0, cb_in[p]} - ycc2rgb_pkg::CHROMA_OFS);
      assign cr_s = signed'({1'b0, cr_in[p]} - ycc2rgb_pkg::CHROMA_OFS);

      assign prod_in[p].ly  = ycc2rgb_pkg::ext_coef(coef.luma) *
                              ycc2rgb_pkg::ext_samp(y_s);
      assign prod_in[p].pr  = ycc2rgb_pkg::ext_coef(coef.cr_red) *
                              ycc2rgb_pkg::ext_samp(cr_s);
      assign prod_in[p].pgr = ycc2rgb_pkg::ext_coef(coef.cr_green) *
                              ycc2rgb_pkg::ext_samp(cr_s);
      assign prod_in[p].pgb = ycc2rgb_pkg::ext_coef(coef.cb_green) *
                              ycc2rgb_pkg::ext_samp(cb_s);
      assign prod_in[p].pb  = ycc2rgb_pkg::ext_coef(coef.cb_blue) *
                              ycc2rgb_pkg::ext_samp(cb_s);
   end

   // stage moves when empty or when the next stage takes its item
   assign adv      = !valid_ff || !out_stall;
   assign in_stall = !adv;
   assign valid_in = adv ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = prod_ff;

endmodule

[rtl/ycc2rgb_sum.sv]
module ycc2rgb_sum #(
   parameter int COEF_FRAC_BITS = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  ycc2rgb_pkg::prod_quad_type  in_data,
   output logic                        out_valid,
   input  logic                        out_stall,
   output ycc2rgb_pkg::sum_quad_type   out_data
);

   localparam logic signed [ycc2rgb_pkg::SUM_W-1:0] HALF =
      ycc2rgb_pkg::SUM_W'(1) << (COEF_FRAC_BITS - 1);

   logic                      adv;
   logic                      valid_ff;
   logic                      valid_in;
   ycc2rgb_pkg::sum_quad_type sum_ff;
   ycc2rgb_pkg::sum_quad_type sum_in;

   for (genvar p = 0; p < ycc2rgb_pkg::NPIX; p++) begin : g_lane
      logic signed [ycc2rgb_pkg::SUM_W-1:0] ly;

      assign ly = ycc2rgb_pkg::ext_prod(in_data[p].ly);

      assign sum_in[p].r = ly + ycc2rgb_pkg::ext_prod(in_data[p].pr) + HALF;
      assign sum_in[p].g = ly - ycc2rgb_pkg::ext_prod(in_data[p].pgr)
                              - ycc2rgb_pkg::ext_prod(in_data[p].pgb) + HALF;
      assign sum_in[p].b = ly + ycc2rgb_pkg::ext_prod(in_data[p].pb) + HALF;
   end

   assign adv      = !valid_ff || !out_stall;
   assign in_stall = !adv;
   assign valid_in = adv ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = sum_ff;

endmodule

[rtl/ycc2rgb_clamp.sv]
module ycc2rgb_clamp #(
   parameter int COEF_FRAC_BITS = 13
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_stall,
   input  ycc2rgb_pkg::sum_quad_type  in_data,
   output logic                       out_valid,
   input  logic                       out_stall,
   output ycc2rgb_pkg::rsp_type       out_data
);

   localparam int W = ycc2rgb_pkg::SUM_W;
   localparam int F = COEF_FRAC_BITS;

   logic                 adv;
   logic                 valid_ff;
   logic                 valid_in;
   ycc2rgb_pkg::rsp_type rsp_ff;
   ycc2rgb_pkg::rsp_type rsp_in;

   logic [ycc2rgb_pkg::PIX_W-1:0] red   [ycc2rgb_pkg::NPIX];
   logic [ycc2rgb_pkg::PIX_W-1:0] green [ycc2rgb_pkg::NPIX];
   logic [ycc2rgb_pkg::PIX_W-1:0] blue  [ycc2rgb_pkg::NPIX];

   // rounded sum: negative gives 0, anything above the 8 result bits gives 255
   function automatic logic [ycc2rgb_pkg::PIX_W-1:0] to_pixel(
      input logic signed [W-1:0] s
   );
      if (s[W-1]) begin
         to_pixel = ycc2rgb_pkg::PIX_MIN;
      end else if (|s[W-2:F+ycc2rgb_pkg::PIX_W]) begin
         to_pixel = ycc2rgb_pkg::PIX_MAX;
      end else begin
         to_pixel = s[F+ycc2rgb_pkg::PIX_W-1:F];
      end
   endfunction

   for (genvar p = 0; p < ycc2rgb_pkg::NPIX; p++) begin : g_lane
      assign red[p]   = to_pixel(in_data[p].r);
      assign green[p] = to_pixel(in_data[p].g);
      assign blue[p]  = to_pixel(in_data[p].b);
   end

   always_comb begin
      rsp_in.red_p0   = red[0];
      rsp_in.red_p1   = red[1];
      rsp_in.red_p2   = red[2];
      rsp_in.red_p3   = red[3];
      rsp_in.green_p0 = green[0];
      rsp_in.green_p1 = green[1];
      rsp_in.green_p2 = green[2];
      rsp_in.green_p3 = green[3];
      rsp_in.blue_p0  = blue[0];
      rsp_in.blue_p1  = blue[1];
      rsp_in.blue_p2  = blue[2];
      rsp_in.blue_p3  = blue[3];
   end

   assign adv      = !valid_ff || !out_stall;
   assign in_stall = !adv;
   assign valid_in = adv ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

[rtl/ycc2rgb_chk.sv]
module ycc2rgb_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ycc2rgb_pkg::rsp_type rsp_data
);

   // a stalled result stays and holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // input only backs up when the output holds a result and is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while pipeline can move");

   // a transfer in passes the multiply, sum and clamp registers to the output when rsp_stall stays low
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted quad did not reach the output in time");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ycbcr_to_rgb_quad ycc2rgb_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
